[rtl/cpv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpv_pkg
// Shared types, constants and helper functions of the cascaded position and
// velocity controller: sequencer states, multiplier tags and saturation.
// ----------------------------------------------------------------------------
package cpv_pkg;

   localparam int CORDIC_W     = 35;
   localparam int CORDIC_ITERS = 17;
   localparam int ACC_W        = 56;
   localparam int MUL_A_W      = 48;
   localparam int MUL_B_W      = 17;
   localparam int PROD_W       = MUL_A_W + MUL_B_W;

   localparam logic signed [15:0] HEAD_MAX    = 16'sd25736;
   localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
   localparam logic signed [16:0] INT_FACTOR  = 17'sd983;
   localparam logic signed [16:0] CORDIC_GAIN = 17'sd39797;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
   localparam logic signed [63:0] S48_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] S48_MIN = -64'sd140737488355328;

   localparam logic [2:0] REG_POS_GAIN_P_X = 3'd0;
   localparam logic [2:0] REG_POS_GAIN_P_Y = 3'd1;
   localparam logic [2:0] REG_POS_GAIN_I   = 3'd2;
   localparam logic [2:0] REG_VEL_GAINS_X  = 3'd3;
   localparam logic [2:0] REG_VEL_GAINS_Y  = 3'd4;
   localparam logic [2:0] REG_VEL_LIMIT    = 3'd5;
   localparam logic [2:0] REG_ATT_LIMIT    = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WVEL, ST_ROT_RUN, ST_ROT_GY, ST_ROT_FIN, ST_MEAS, ST_LATCH,
      ST_PINT, ST_OUT_Q, ST_OUT_P, ST_OUT_I, ST_OUT_W, ST_OUT_SAVE, ST_SP_SAVE,
      ST_IN_Q, ST_IN_P, ST_IN_I, ST_IN_D, ST_IN_W, ST_IN_SAVE, ST_FINAL, ST_DONE
   } state_type;

   // What to do with the product once it is registered.
   typedef enum logic [2:0] {
      TAG_NONE, TAG_Q, TAG_LOAD, TAG_ADD, TAG_RX, TAG_RY
   } tag_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
      tag_type                   tag;
   } mul_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = 32'sh7FFFFFFF;
      else if (v < S32_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [47:0] r;
      if (v > S48_MAX) r = 48'sh7FFFFFFFFFFF;
      else if (v < S48_MIN) r = 48'sh800000000000;
      else r = v[47:0];
      return r;
   endfunction

   // Arctangent of 2^-i with 16 fractional bits.
   function automatic logic [16:0] atan_entry(input logic [4:0] idx);
      logic [16:0] r;
      unique case (idx)
         5'd0:    r = 17'd51472;
         5'd1:    r = 17'd30386;
         5'd2:    r = 17'd16055;
         5'd3:    r = 17'd8150;
         5'd4:    r = 17'd4091;
         5'd5:    r = 17'd2047;
         5'd6:    r = 17'd1024;
         5'd7:    r = 17'd512;
         5'd8:    r = 17'd256;
         5'd9:    r = 17'd128;
         5'd10:   r = 17'd64;
         5'd11:   r = 17'd32;
         5'd12:   r = 17'd16;
         5'd13:   r = 17'd8;
         5'd14:   r = 17'd4;
         5'd15:   r = 17'd2;
         5'd16:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // Exact division by ten for any 16-bit value via reciprocal multiply.
   function automatic logic [15:0] div10(input logic [15:0] v);
      logic [31:0] prod;
      prod = v * 16'd52429;
      return 16'(prod[31:19]);
   endfunction

endpackage
`default_nettype wire

[rtl/cpv_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpv_mul
// Shared signed 48x17 multiplier with a registered product. The request tag
// travels with the product so the sequencer knows where it goes.
// ----------------------------------------------------------------------------
module cpv_mul
   import cpv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mul_req_type              req,
   output logic signed [PROD_W-1:0] prod_ff,
   output tag_type                  tag_ff
);

   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = req.a * req.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TAG_NONE;
      end else begin
         tag_ff <= req.tag;
      end
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

[rtl/cpv_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpv_cordic
// Iterative rotation of a vector by minus the heading: quarter-turn
// prerotation, then one shift-add micro-rotation per cycle, gain not applied.
// ----------------------------------------------------------------------------
module cpv_cordic
   import cpv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [31:0]         vec_x,
   input  logic signed [31:0]         vec_y,
   input  logic signed [15:0]         heading,
   output logic                       done_ff,
   output logic signed [CORDIC_W-1:0] x_ff,
   output logic signed [CORDIC_W-1:0] y_ff
);

   logic signed [CORDIC_W-1:0] x_in, y_in, xs, ys, dx, dy;
   logic signed [19:0]         z_ff, z_in, z_start, ang;
   logic signed [15:0]         h_c;
   logic [4:0]                 iter_ff, iter_in;
   logic                       busy_ff, busy_in, done_in;

   always_comb begin
      h_c = heading;
      if (heading > HEAD_MAX) h_c = HEAD_MAX;
      else if (heading < -HEAD_MAX) h_c = -HEAD_MAX;
      z_start = -(20'(h_c) <<< 3);
      xs = CORDIC_W'(vec_x);
      ys = CORDIC_W'(vec_y);

      dx  = y_ff >>> iter_ff;
      dy  = x_ff >>> iter_ff;
      ang = $signed({3'b000, atan_entry(iter_ff)});

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         busy_in = 1'b1;
         iter_in = 5'd0;
         if (z_start > ANG_HALF_PI) begin
            x_in = -ys;
            y_in = xs;
            z_in = z_start - ANG_HALF_PI;
         end else if (z_start < -ANG_HALF_PI) begin
            x_in = ys;
            y_in = -xs;
            z_in = z_start + ANG_HALF_PI;
         end else begin
            x_in = xs;
            y_in = ys;
            z_in = z_start;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         iter_in = iter_ff + 5'd1;
         if (iter_ff == 5'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("rotation restarted while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("done without a finished rotation");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> iter_ff < 5'(CORDIC_ITERS))
      else $error("iteration count out of range");
`endif

endmodule
`default_nettype wire

[rtl/cascaded_position_velocity_pid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pid
// Cascaded position PI and velocity PID controller, one request per tick.
// A valid sample once started runs two rotations and the shared multiplier
// sequence; an invalid sample once started runs one rotation only, and the
// first valid sample and those before it run no rotation. One request at a
// time; the next one is taken the cycle after the response register loads.
// The response register stalls while full.
// Reset is synchronous and active high; it clears all loop state and flags.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_pid
   import cpv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [15:0] req_heading,
   input  logic               req_sample_valid,
   input  logic               req_offboard,
   input  logic [15:0]        req_obstacle_dist,
   input  logic               req_obstacle_valid,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pitch_cmd,
   output logic signed [31:0] rsp_roll_cmd,
   output logic signed [31:0] rsp_vel_cmd_x,
   output logic signed [31:0] rsp_vel_cmd_y_neg,
   output logic               rsp_vel_limit_hit,
   output logic               rsp_att_limit_hit,
   output logic               rsp_updated,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);

   state_type state_ff, state_in;

   // Configuration.
   logic signed [15:0] gain_px_ff, gain_py_ff, gain_i_ff;
   logic [47:0]        vgx_ff, vgy_ff;
   logic [30:0]        vlim_ff, alim_ff;

   // Latched request.
   logic signed [31:0] pos_x_ff, pos_y_ff, tgt_x_ff, tgt_y_ff;
   logic signed [15:0] hd_ff;
   logic               smp_ff, off_ff, obs_ff;
   logic [15:0]        dist_ff;

   // Loop state.
   logic signed [31:0] last_pos_x_ff, last_pos_x_in, last_pos_y_ff, last_pos_y_in;
   logic signed [31:0] meas_x_ff, meas_x_in, meas_y_ff, meas_y_in;
   logic signed [31:0] last_vel_x_ff, last_vel_x_in, last_vel_y_ff, last_vel_y_in;
   logic signed [47:0] pint_x_ff, pint_x_in, pint_y_ff, pint_y_in;
   logic signed [47:0] vint_x_ff, vint_x_in, vint_y_ff, vint_y_in;
   logic signed [31:0] pitch_ff, pitch_in, roll_ff, roll_in;
   logic signed [31:0] hvx_ff, hvx_in, hvy_ff, hvy_in;
   logic               started_ff, started_in;
   logic               vel_sticky_ff, vel_sticky_in, att_sticky_ff, att_sticky_in;

   // Working registers.
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [47:0]      q_ff, q_in;
   logic signed [31:0]      rot_x_ff, rot_x_in, rot_y_ff, rot_y_in, sw_x_ff, sw_x_in;
   logic                    axis_ff, axis_in, phase_ff, phase_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_pitch_ff, rsp_pitch_in, rsp_roll_ff, rsp_roll_in;
   logic signed [31:0] rsp_vx_ff, rsp_vx_in, rsp_vyn_ff, rsp_vyn_in;
   logic               rsp_vhit_ff, rsp_vhit_in, rsp_ahit_ff, rsp_ahit_in;
   logic               rsp_upd_ff, rsp_upd_in;

   // Shared units.
   mul_req_type              mul_req;
   logic signed [PROD_W-1:0] prod;
   tag_type                  mul_tag;
   logic                     cordic_start, cordic_done;
   logic signed [31:0]       cordic_vx, cordic_vy;
   logic signed [CORDIC_W-1:0] cordic_x, cordic_y;

   // Combinational helpers.
   logic                accept, load_rsp;
   logic signed [32:0]  dpx, dpy, ex_x, ex_y, ax_ex, ax_ev, ax_dv;
   logic signed [36:0]  w15x, w15y, ax_d15;
   logic signed [31:0]  wx, wy, acc_sat, clx, cly, clp, clr;
   logic signed [31:0]  ax_meas, ax_sp, ax_lv;
   logic signed [47:0]  ax_pint, ax_vint;
   logic signed [15:0]  ax_gp, ax_kp, ax_ki, ax_kd;
   logic signed [31:0]  vlim_s, alim_s;
   logic [15:0]         obs_num;
   logic [8:0]          obs_diff;
   logic                near;

   cpv_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .prod_ff (prod),
      .tag_ff  (mul_tag)
   );

   cpv_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .vec_x   (cordic_vx),
      .vec_y   (cordic_vy),
      .heading (hd_ff),
      .done_ff (cordic_done),
      .x_ff    (cordic_x),
      .y_ff    (cordic_y)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      dpx  = 33'(pos_x_ff) - 33'(last_pos_x_ff);
      dpy  = 33'(pos_y_ff) - 33'(last_pos_y_ff);
      w15x = (37'(dpx) <<< 4) - 37'(dpx);
      w15y = (37'(dpy) <<< 4) - 37'(dpy);
      wx   = sat32(64'(w15x));
      wy   = sat32(64'(w15y));
      ex_x = 33'(tgt_x_ff) - 33'(pos_x_ff);
      ex_y = 33'(tgt_y_ff) - 33'(pos_y_ff);

      ax_ex   = axis_ff ? ex_y : ex_x;
      ax_pint = axis_ff ? pint_y_ff : pint_x_ff;
      ax_vint = axis_ff ? vint_y_ff : vint_x_ff;
      ax_gp   = axis_ff ? gain_py_ff : gain_px_ff;
      ax_meas = axis_ff ? meas_y_ff : meas_x_ff;
      ax_sp   = axis_ff ? hvy_ff : hvx_ff;
      ax_lv   = axis_ff ? last_vel_y_ff : last_vel_x_ff;
      ax_kp   = axis_ff ? $signed(vgy_ff[15:0])  : $signed(vgx_ff[15:0]);
      ax_ki   = axis_ff ? $signed(vgy_ff[31:16]) : $signed(vgx_ff[31:16]);
      ax_kd   = axis_ff ? $signed(vgy_ff[47:32]) : $signed(vgx_ff[47:32]);
      ax_ev   = 33'(ax_meas) - 33'(ax_sp);
      ax_dv   = 33'(ax_meas) - 33'(ax_lv);
      ax_d15  = (37'(ax_dv) <<< 4) - 37'(ax_dv);

      acc_sat = sat32(64'(acc_ff));
      vlim_s  = $signed({1'b0, vlim_ff});
      alim_s  = $signed({1'b0, alim_ff});

      if (rot_x_ff > vlim_s) clx = vlim_s;
      else if (rot_x_ff < -vlim_s) clx = -vlim_s;
      else clx = rot_x_ff;
      if (rot_y_ff > vlim_s) cly = vlim_s;
      else if (rot_y_ff < -vlim_s) cly = -vlim_s;
      else cly = rot_y_ff;
      if (pitch_ff > alim_s) clp = alim_s;
      else if (pitch_ff < -alim_s) clp = -alim_s;
      else clp = pitch_ff;
      if (roll_ff > alim_s) clr = alim_s;
      else if (roll_ff < -alim_s) clr = -alim_s;
      else clr = roll_ff;

      // The override only applies for a valid forward reading from 6 to 255.
      near     = obs_ff && (dist_ff[15:8] == 8'd0) && (dist_ff > 16'd5);
      obs_diff = 9'd256 - {1'b0, dist_ff[7:0]};
      obs_num  = {obs_diff[7:0], 8'd0} + 16'd5;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = started_ff ? ST_WVEL : ST_LATCH;
         ST_WVEL:     state_in = ST_ROT_RUN;
         ST_ROT_RUN:  if (cordic_done) state_in = ST_ROT_GY;
         ST_ROT_GY:   state_in = ST_ROT_FIN;
         ST_ROT_FIN:  state_in = phase_ff ? ST_SP_SAVE : ST_MEAS;
         ST_MEAS:     state_in = ST_LATCH;
         ST_LATCH: begin
            priority if (smp_ff && started_ff) state_in = ST_PINT;
            else if (smp_ff) state_in = ST_FINAL;
            else state_in = ST_DONE;
         end
         ST_PINT:     state_in = ST_OUT_Q;
         ST_OUT_Q:    state_in = ST_OUT_P;
         ST_OUT_P:    state_in = ST_OUT_I;
         ST_OUT_I:    state_in = ST_OUT_W;
         ST_OUT_W:    state_in = ST_OUT_SAVE;
         ST_OUT_SAVE: state_in = axis_ff ? ST_ROT_RUN : ST_OUT_Q;
         ST_SP_SAVE:  state_in = ST_IN_Q;
         ST_IN_Q:     state_in = ST_IN_P;
         ST_IN_P:     state_in = ST_IN_I;
         ST_IN_I:     state_in = ST_IN_D;
         ST_IN_D:     state_in = ST_IN_W;
         ST_IN_W:     state_in = ST_IN_SAVE;
         ST_IN_SAVE:  state_in = axis_ff ? ST_FINAL : ST_IN_Q;
         ST_FINAL:    state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath control and next values.
   always_comb begin
      mul_req       = '{a: '0, b: '0, tag: TAG_NONE};
      cordic_start  = 1'b0;
      cordic_vx     = wx;
      cordic_vy     = wy;

      last_pos_x_in = last_pos_x_ff;
      last_pos_y_in = last_pos_y_ff;
      meas_x_in     = meas_x_ff;
      meas_y_in     = meas_y_ff;
      last_vel_x_in = last_vel_x_ff;
      last_vel_y_in = last_vel_y_ff;
      pint_x_in     = pint_x_ff;
      pint_y_in     = pint_y_ff;
      vint_x_in     = vint_x_ff;
      vint_y_in     = vint_y_ff;
      pitch_in      = pitch_ff;
      roll_in       = roll_ff;
      hvx_in        = hvx_ff;
      hvy_in        = hvy_ff;
      started_in    = started_ff;
      vel_sticky_in = vel_sticky_ff;
      att_sticky_in = att_sticky_ff;
      acc_in        = acc_ff;
      q_in          = q_ff;
      rot_x_in      = rot_x_ff;
      rot_y_in      = rot_y_ff;
      sw_x_in       = sw_x_ff;
      axis_in       = axis_ff;
      phase_in      = phase_ff;

      // Product from the previous cycle lands according to its tag.
      unique case (mul_tag)
         TAG_Q:    q_in = $signed(prod[63:16]);
         TAG_LOAD: acc_in = $signed(prod[63:8]);
         TAG_ADD:  acc_in = acc_ff + $signed(prod[63:8]);
         TAG_RX:   rot_x_in = sat32(64'($signed(prod[63:16])));
         TAG_RY:   rot_y_in = sat32(64'($signed(prod[63:16])));
         default:  ;
      endcase

      unique case (state_ff)
         ST_WVEL: begin
            cordic_start = 1'b1;
            phase_in     = 1'b0;
         end
         ST_ROT_RUN: begin
            if (cordic_done) begin
               mul_req = '{a: 48'(cordic_x), b: CORDIC_GAIN, tag: TAG_RX};
            end
         end
         ST_ROT_GY: mul_req = '{a: 48'(cordic_y), b: CORDIC_GAIN, tag: TAG_RY};
         ST_MEAS: begin
            meas_x_in = rot_x_ff;
            meas_y_in = rot_y_ff;
         end
         ST_LATCH: begin
            last_pos_x_in = pos_x_ff;
            last_pos_y_in = pos_y_ff;
         end
         ST_PINT: begin
            pint_x_in = off_ff ? sat48(64'(pint_x_ff) + 64'(ex_x)) : '0;
            pint_y_in = off_ff ? sat48(64'(pint_y_ff) + 64'(ex_y)) : '0;
            axis_in   = 1'b0;
         end
         ST_OUT_Q: mul_req = '{a: ax_pint, b: INT_FACTOR, tag: TAG_Q};
         ST_OUT_P: mul_req = '{a: 48'(ax_ex), b: 17'(ax_gp), tag: TAG_LOAD};
         ST_OUT_I: mul_req = '{a: q_ff, b: off_ff ? 17'(gain_i_ff) : 17'sd0, tag: TAG_ADD};
         ST_OUT_SAVE: begin
            if (!axis_ff) begin
               sw_x_in = acc_sat;
               axis_in = 1'b1;
            end else begin
               cordic_start = 1'b1;
               cordic_vx    = sw_x_ff;
               cordic_vy    = acc_sat;
               phase_in     = 1'b1;
            end
         end
         ST_SP_SAVE: begin
            // The integral sees the setpoint before the clamp.
            vint_x_in = off_ff ?
               sat48(64'(vint_x_ff) + 64'(meas_x_ff) - 64'(rot_x_ff)) : '0;
            vint_y_in = off_ff ?
               sat48(64'(vint_y_ff) + 64'(meas_y_ff) - 64'(rot_y_ff)) : '0;
            hvx_in    = clx;
            hvy_in    = cly;
            if (clx != rot_x_ff || cly != rot_y_ff) vel_sticky_in = 1'b1;
            axis_in   = 1'b0;
         end
         ST_IN_Q: mul_req = '{a: ax_vint, b: INT_FACTOR, tag: TAG_Q};
         ST_IN_P: mul_req = '{a: 48'(ax_ev), b: 17'(ax_kp), tag: TAG_LOAD};
         ST_IN_I: mul_req = '{a: q_ff, b: off_ff ? 17'(ax_ki) : 17'sd0, tag: TAG_ADD};
         ST_IN_D: mul_req = '{a: 48'(ax_d15), b: 17'(ax_kd), tag: TAG_ADD};
         ST_IN_SAVE: begin
            if (!axis_ff) begin
               pitch_in = acc_sat;
               axis_in  = 1'b1;
            end else begin
               roll_in  = acc_sat;
            end
         end
         ST_FINAL: begin
            last_vel_x_in = meas_x_ff;
            last_vel_y_in = meas_y_ff;
            started_in    = 1'b1;
            roll_in       = clr;
            pitch_in      = near ? 32'(div10(obs_num)) : clp;
            if (clp != pitch_ff || clr != roll_ff) att_sticky_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_roll_in  = rsp_roll_ff;
      rsp_vx_in    = rsp_vx_ff;
      rsp_vyn_in   = rsp_vyn_ff;
      rsp_vhit_in  = rsp_vhit_ff;
      rsp_ahit_in  = rsp_ahit_ff;
      rsp_upd_in   = rsp_upd_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_pitch_in = pitch_ff;
         rsp_roll_in  = roll_ff;
         rsp_vx_in    = hvx_ff;
         rsp_vyn_in   = -hvy_ff;
         rsp_vhit_in  = vel_sticky_ff;
         rsp_ahit_in  = att_sticky_ff;
         rsp_upd_in   = smp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gain_px_ff    <= '0;
         gain_py_ff    <= '0;
         gain_i_ff     <= '0;
         vgx_ff        <= '0;
         vgy_ff        <= '0;
         vlim_ff       <= 31'd65536;
         alim_ff       <= 31'd19661;
         last_pos_x_ff <= '0;
         last_pos_y_ff <= '0;
         meas_x_ff     <= '0;
         meas_y_ff     <= '0;
         last_vel_x_ff <= '0;
         last_vel_y_ff <= '0;
         pint_x_ff     <= '0;
         pint_y_ff     <= '0;
         vint_x_ff     <= '0;
         vint_y_ff     <= '0;
         pitch_ff      <= '0;
         roll_ff       <= '0;
         hvx_ff        <= '0;
         hvy_ff        <= '0;
         started_ff    <= 1'b0;
         vel_sticky_ff <= 1'b0;
         att_sticky_ff <= 1'b0;
         axis_ff       <= 1'b0;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_POS_GAIN_P_X: gain_px_ff <= $signed(csr_wdata[15:0]);
               REG_POS_GAIN_P_Y: gain_py_ff <= $signed(csr_wdata[15:0]);
               REG_POS_GAIN_I:   gain_i_ff  <= $signed(csr_wdata[15:0]);
               REG_VEL_GAINS_X:  vgx_ff     <= csr_wdata;
               REG_VEL_GAINS_Y:  vgy_ff     <= csr_wdata;
               REG_VEL_LIMIT:    vlim_ff    <= csr_wdata[30:0];
               REG_ATT_LIMIT:    alim_ff    <= csr_wdata[30:0];
               default: ;
            endcase
         end
         last_pos_x_ff <= last_pos_x_in;
         last_pos_y_ff <= last_pos_y_in;
         meas_x_ff     <= meas_x_in;
         meas_y_ff     <= meas_y_in;
         last_vel_x_ff <= last_vel_x_in;
         last_vel_y_ff <= last_vel_y_in;
         pint_x_ff     <= pint_x_in;
         pint_y_ff     <= pint_y_in;
         vint_x_ff     <= vint_x_in;
         vint_y_ff     <= vint_y_in;
         pitch_ff      <= pitch_in;
         roll_ff       <= roll_in;
         hvx_ff        <= hvx_in;
         hvy_ff        <= hvy_in;
         started_ff    <= started_in;
         vel_sticky_ff <= vel_sticky_in;
         att_sticky_ff <= att_sticky_in;
         axis_ff       <= axis_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (accept) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         tgt_x_ff <= req_target_x;
         tgt_y_ff <= req_target_y;
         hd_ff    <= req_heading;
         smp_ff   <= req_sample_valid;
         off_ff   <= req_offboard;
         dist_ff  <= req_obstacle_dist;
         obs_ff   <= req_obstacle_valid;
      end
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      rot_x_ff    <= rot_x_in;
      rot_y_ff    <= rot_y_in;
      sw_x_ff     <= sw_x_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_roll_ff  <= rsp_roll_in;
      rsp_vx_ff    <= rsp_vx_in;
      rsp_vyn_ff   <= rsp_vyn_in;
      rsp_vhit_ff  <= rsp_vhit_in;
      rsp_ahit_ff  <= rsp_ahit_in;
      rsp_upd_ff   <= rsp_upd_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pitch_cmd     = rsp_pitch_ff;
   assign rsp_roll_cmd      = rsp_roll_ff;
   assign rsp_vel_cmd_x     = rsp_vx_ff;
   assign rsp_vel_cmd_y_neg = rsp_vyn_ff;
   assign rsp_vel_limit_hit = rsp_vhit_ff;
   assign rsp_att_limit_hit = rsp_ahit_ff;
   assign rsp_updated       = rsp_upd_ff;

`ifndef NO_ASSERTIONS
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !$fell(vel_sticky_ff) && !$fell(att_sticky_ff) && !$fell(started_ff))
      else $error("sticky flag or started cleared outside reset");
   a_cordic_in_run: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_ROT_RUN)
      else $error("rotation finished outside its wait state");
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      accept |-> mul_tag == TAG_NONE)
      else $error("request accepted with a product still in flight");
`endif

endmodule
`default_nettype wire
